/* src/u8d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared constants for the strict UTF-8 decoder: result kinds, error codes,
// byte classes and the bounds of valid scalar values.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned VALUE_W = 21;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned LEN_W   = 3;

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [LEN_W-1:0]   t_len;

    localparam t_kind KIND_SCALAR = 2'd0;
    localparam t_kind KIND_ERROR  = 2'd1;
    localparam t_kind KIND_END    = 2'd2;

    localparam t_code ERR_LEAD      = 3'd0;
    localparam t_code ERR_TRUNCATED = 3'd1;
    localparam t_code ERR_CONT      = 3'd2;
    localparam t_code ERR_OVERLONG  = 3'd3;
    localparam t_code ERR_SURROGATE = 3'd4;
    localparam t_code ERR_RANGE     = 3'd5;

    localparam t_len LEN_NONE  = 3'd0;
    localparam t_len LEN_ONE   = 3'd1;
    localparam t_len LEN_TWO   = 3'd2;
    localparam t_len LEN_THREE = 3'd3;
    localparam t_len LEN_FOUR  = 3'd4;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [5:0] CONT_BITS  = 6'h3F;

    localparam t_value MIN_TWO       = 21'h00080;
    localparam t_value MIN_THREE     = 21'h00800;
    localparam t_value MIN_FOUR      = 21'h10000;
    localparam t_value SURR_MIN      = 21'h0D800;
    localparam t_value SURR_MAX      = 21'h0DFFF;
    localparam t_value SCALAR_MAX    = 21'h10FFFF;

endpackage

/* src/u8d_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_byte_if / u8d_result_if
// Valid/ready channels of the UTF-8 decoder: input bytes and decoded results.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8d_result_if #(
    parameter int unsigned OFFSET_BITS = 32
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [20:0]            scalar_value;
    logic [2:0]             error_code;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic                   text_done;

    modport source (
        output valid, output kind, output scalar_value, output error_code,
        output byte_offset, output text_done, input ready
    );
    modport sink (
        input valid, input kind, input scalar_value, input error_code,
        input byte_offset, input text_done, output ready
    );
endinterface

/* src/utf8_validating_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validating_decoder_core
// Strict streaming UTF-8 decoder: one byte in, at most one result out.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte   : one text byte per word, end_of_text marks the text's last byte.
//   o_result : scalar values as they complete, one error word at the first
//              error of a text (code and byte offset), then an end marker on
//              the last byte if later. text_done is set on the word the last
//              byte causes; then the next byte starts a new text at offset 0.
//   Throughput: one byte per cycle while i_byte.ready is high; the decode
//   step is one layer of logic from the decoder state and the input byte
//   into a result register.
//   Each result is registered into the result register or the skid register.
//   Stall: a two-entry output stage (result register plus skid register)
//   keeps i_byte.ready high while one result waits; ready drops only when
//   both entries are full.
//   Reset: synchronous, active low; clears decoder state and empties the
//   output stage. No clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_core #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    u8d_byte_if.sink       i_byte,
    u8d_result_if.source   o_result
);
    import u8d_pkg::*;

    typedef logic [OFFSET_BITS-1:0] t_offset;

    typedef struct packed {
        t_kind   kind;
        t_value  scalar_value;
        t_code   error_code;
        t_offset byte_offset;
        logic    text_done;
    } t_result;

    localparam t_offset OFFSET_MAX = {OFFSET_BITS{1'b1}};

    t_len    r_len,      n_len;
    t_len    r_rcv,      n_rcv;
    t_value  r_accum,    n_accum;
    t_offset r_start,    n_start;
    t_offset r_pos,      n_pos;
    logic    r_pend,     n_pend;
    t_offset r_pend_off, n_pend_off;
    logic    r_err,      n_err;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    res_valid;
    t_result res;
    logic    accept, take, push;
    logic    [7:0] b;
    logic    last;
    t_value  min_val;

    assign b      = i_byte.in_byte;
    assign last   = i_byte.end_of_text;
    assign accept = i_byte.valid & i_byte.ready;
    assign take   = o_result.valid & o_result.ready;
    assign push   = accept & res_valid;

    assign i_byte.ready = !r_skid_valid;

    always_comb begin
        n_len      = r_len;
        n_rcv      = r_rcv;
        n_accum    = r_accum;
        n_start    = r_start;
        n_pend     = r_pend;
        n_pend_off = r_pend_off;
        n_err      = r_err;
        n_pos      = (r_pos == OFFSET_MAX) ? r_pos : r_pos + t_offset'(1);
        res_valid  = 1'b0;
        res        = '0;
        res.text_done = last;
        min_val    = MIN_FOUR;

        if (r_err) begin
            if (last) begin
                res_valid = 1'b1;
                res.kind  = KIND_END;
            end
        end else if (r_len == LEN_NONE) begin
            if (b inside {[8'h00:ASCII_MAX]}) begin
                res_valid        = 1'b1;
                res.kind         = KIND_SCALAR;
                res.scalar_value = t_value'(b);
            end else if (b inside {[LEAD2_MIN:LEAD2_MAX], [LEAD3_MIN:LEAD3_MAX],
                                   [LEAD4_MIN:LEAD4_MAX]}) begin
                if (b inside {[LEAD2_MIN:LEAD2_MAX]}) begin
                    n_len   = LEN_TWO;
                    n_accum = t_value'(b[4:0]);
                end else if (b inside {[LEAD3_MIN:LEAD3_MAX]}) begin
                    n_len   = LEN_THREE;
                    n_accum = t_value'(b[3:0]);
                end else begin
                    n_len   = LEN_FOUR;
                    n_accum = t_value'(b[2:0]);
                end
                n_rcv      = LEN_ONE;
                n_start    = r_pos;
                n_pend     = 1'b0;
                n_pend_off = '0;
                if (last) begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_ERROR;
                    res.error_code  = ERR_TRUNCATED;
                    res.byte_offset = r_pos;
                end
            end else begin
                res_valid       = 1'b1;
                res.kind        = KIND_ERROR;
                res.error_code  = ERR_LEAD;
                res.byte_offset = r_pos;
            end
        end else begin
            n_rcv = r_rcv + LEN_ONE;
            if (!r_pend) begin
                if ((b & CONT_MASK) != CONT_TAG) begin
                    n_pend     = 1'b1;
                    n_pend_off = r_pos;
                end else begin
                    n_accum = {r_accum[VALUE_W-7:0], b[5:0] & CONT_BITS};
                end
            end
            case (r_len)
                LEN_TWO:   min_val = MIN_TWO;
                LEN_THREE: min_val = MIN_THREE;
                default:   min_val = MIN_FOUR;
            endcase
            if (n_rcv >= r_len) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                if (n_pend) begin
                    res.error_code  = ERR_CONT;
                    res.byte_offset = n_pend_off;
                end else if (n_accum < min_val) begin
                    res.error_code  = ERR_OVERLONG;
                    res.byte_offset = r_start;
                end else if (n_accum >= SURR_MIN && n_accum <= SURR_MAX) begin
                    res.error_code  = ERR_SURROGATE;
                    res.byte_offset = r_start;
                end else if (n_accum > SCALAR_MAX) begin
                    res.error_code  = ERR_RANGE;
                    res.byte_offset = r_start;
                end else begin
                    res.kind         = KIND_SCALAR;
                    res.scalar_value = n_accum;
                    n_len            = LEN_NONE;
                    n_rcv            = LEN_NONE;
                    n_accum          = '0;
                    n_pend           = 1'b0;
                    n_pend_off       = '0;
                end
            end else if (last) begin
                res_valid       = 1'b1;
                res.kind        = KIND_ERROR;
                res.error_code  = ERR_TRUNCATED;
                res.byte_offset = r_start;
            end
        end

        // close the text on its last byte, close the sequence on an error
        if (res_valid && last) begin
            n_len      = LEN_NONE;
            n_rcv      = LEN_NONE;
            n_accum    = '0;
            n_start    = '0;
            n_pos      = '0;
            n_pend     = 1'b0;
            n_pend_off = '0;
            n_err      = 1'b0;
        end else if (res_valid && res.kind == KIND_ERROR) begin
            n_len      = LEN_NONE;
            n_rcv      = LEN_NONE;
            n_accum    = '0;
            n_pend     = 1'b0;
            n_pend_off = '0;
            n_err      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_NONE;
            r_rcv      <= LEN_NONE;
            r_accum    <= '0;
            r_start    <= '0;
            r_pos      <= '0;
            r_pend     <= 1'b0;
            r_pend_off <= '0;
            r_err      <= 1'b0;
        end else if (accept) begin
            r_len      <= n_len;
            r_rcv      <= n_rcv;
            r_accum    <= n_accum;
            r_start    <= n_start;
            r_pos      <= n_pos;
            r_pend     <= n_pend;
            r_pend_off <= n_pend_off;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= res;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.kind         = r_out.kind;
    assign o_result.scalar_value = r_out.scalar_value;
    assign o_result.error_code   = r_out.error_code;
    assign o_result.byte_offset  = r_out.byte_offset;
    assign o_result.text_done    = r_out.text_done;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_seq_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == LEN_NONE) |-> (r_rcv == LEN_NONE && !r_pend))
        else $error("sequence counters set with no open sequence");

    a_open_seq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != LEN_NONE) |-> (r_rcv != LEN_NONE && r_rcv < r_len && !r_err))
        else $error("open sequence count out of bounds");

    a_done_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_valid && last) |=> (r_pos == '0 && !r_err))
        else $error("text end did not restart the offset");
`endif

endmodule
